// ===== rtl/core/range_kth_smallest_query_defines.svh =====
// Assertion macros used by the range k-th smallest query top level.
`ifndef RANGE_KTH_SMALLEST_QUERY_DEFINES_SVH
`define RANGE_KTH_SMALLEST_QUERY_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define RKQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rkq check failed: same-cycle implication");

// Check that the consequent holds in the cycle after the antecedent.
`define RKQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rkq check failed: next-cycle implication");

`endif

// ===== rtl/core/rkq_pkg.sv =====
// Package with types and constants of the range k-th smallest query block.
`timescale 1ns / 1ps
`default_nettype none

package rkq_pkg;

    // Number of counting cells in the chain and the bits of a lane index.
    localparam int NUM_CELLS = 32;
    localparam int LANE_W    = $clog2(NUM_CELLS);

    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int DEF_ROW_W        = 5;
    localparam int DEF_PART_W       = $clog2(NUM_CELLS + 1);

    // Width of the position and rank fields.
    localparam int POS_W = 11;

    localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef struct packed {
        t_action             action;
        logic signed [31:0]  value;
        logic [POS_W-1:0]    left;
        logic [POS_W-1:0]    right;
        logic [POS_W-1:0]    rank;
    } t_query_word;

    typedef struct packed {
        logic signed [31:0]  kth_value;
        logic                error;
    } t_result_word;

endpackage

`default_nettype wire

// ===== rtl/core/range_kth_smallest_query.sv =====
// Top level of the range k-th smallest query block: sequencer and chain of counting cells.
// Clear, append and an unused action give no result word.
// A query takes up to 32 search rounds; each round feeds the NUM_CELLS-wide rows of the
// store that the range touches through the cell chain, one row read per cell, and then
// drains the chain. A bad query answers without a search.
// Reset (synchronous, active low) empties the array and restores the running min and max.
`timescale 1ns / 1ps
`default_nettype none

`include "range_kth_smallest_query_defines.svh"

module range_kth_smallest_query import rkq_pkg::*; #(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  t_query_word  i_word,
    output logic         o_valid,
    input  logic         i_ready,
    output t_result_word o_word
);

    // Count of stored elements, rows of each bank and derived widths.
    localparam int CNT_W      = $clog2(MAX_ELEMENTS + 1);
    localparam int ROWS       = (MAX_ELEMENTS + NUM_CELLS - 1) / NUM_CELLS;
    localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W      = ROW_W + LANE_W;
    localparam int PART_W     = $clog2(NUM_CELLS + 1);
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int LEN_W      = POS_W + 1;
    localparam int DRAIN_LAST = NUM_CELLS + 1;
    localparam int DRN_W      = $clog2(DRAIN_LAST + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_STEP  = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    // Midpoint rounded toward minus infinity of (lo + hi + 1) / 2, wide enough not to wrap.
    function automatic logic signed [32:0] f_mid(input logic signed [32:0] lo,
                                                 input logic signed [32:0] hi);
        logic signed [33:0] sum;
        sum = 34'(lo) + 34'(hi) + 34'sd1;
        return sum[33:1];
    endfunction

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic signed [31:0] r_min;
    logic signed [31:0] r_max;
    logic signed [32:0] r_lo;
    logic signed [32:0] r_hi;
    logic signed [32:0] r_mid;
    logic [IDX_W-1:0]   r_first;
    logic [IDX_W-1:0]   r_last;
    logic [ROW_W-1:0]   r_row_first;
    logic [ROW_W-1:0]   r_row_last;
    logic [ROW_W-1:0]   r_row;
    logic [POS_W-1:0]   r_rank;
    logic               r_err;
    logic [CNT_W-1:0]   r_total;
    logic [DRN_W-1:0]   r_drain;
    logic [ROW_W-1:0]   r_tok_row;
    logic               r_tok_valid;
    logic               r_out_valid;
    t_result_word       r_out;

    logic signed [32:0] n_lo;
    logic signed [32:0] n_hi;

    logic               w_accept;
    logic               w_append_go;
    logic               w_bad;
    logic [LEN_W-1:0]   w_len;
    logic [IDX_W-1:0]   w_first;
    logic [IDX_W-1:0]   w_last;

    // Cell chain links: index 0 is fed by the sequencer.
    logic [ROW_W-1:0]   w_row        [NUM_CELLS+1];
    logic               w_row_valid  [NUM_CELLS+1];
    logic [PART_W-1:0]  w_part       [NUM_CELLS+1];
    logic               w_part_valid [NUM_CELLS];
    logic               w_tail_valid;
    logic [PART_W-1:0]  w_tail_part;

    // Take a new word only between commands; a waiting result does not block intake.
    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;

    assign w_append_go = w_accept && (i_word.action == ACT_APPEND) &&
                         (r_count < CNT_W'(MAX_ELEMENTS));

    // Range length is only meaningful when right >= left; the compare guards it.
    assign w_len = LEN_W'(i_word.right) - LEN_W'(i_word.left) + LEN_W'(1);
    assign w_bad = (i_word.left == '0) || (i_word.right < i_word.left) ||
                   (CMP_W'(i_word.right) > CMP_W'(r_count)) || (i_word.rank == '0) ||
                   (LEN_W'(i_word.rank) > w_len);

    // Zero-based bounds; a valid query keeps them below the store depth.
    assign w_first = IDX_W'(i_word.left - POS_W'(1));
    assign w_last  = IDX_W'(i_word.right - POS_W'(1));

    // Raise lo to mid when fewer than rank elements lie below mid, else pull hi under mid.
    always_comb begin
        if (CMP_W'(r_total) < CMP_W'(r_rank)) begin
            n_lo = r_mid;
            n_hi = r_hi;
        end else begin
            n_lo = r_lo;
            n_hi = r_mid - 33'sd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_min       <= VALUE_MAX;
            r_max       <= VALUE_MIN;
            r_tok_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the result word once taken, unless a new one replaces it.
            if (r_out_valid && i_ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            // Sum the per-row counts as they leave the tail of the chain.
            if (w_tail_valid) begin
                r_total <= r_total + CNT_W'(w_tail_part);
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        unique case (i_word.action)
                            ACT_CLEAR: begin
                                r_count <= '0;
                                r_min   <= VALUE_MAX;
                                r_max   <= VALUE_MIN;
                            end
                            ACT_APPEND: begin
                                // Drop the append entirely when the store is full.
                                if (w_append_go) begin
                                    r_count <= r_count + CNT_W'(1);
                                    if (i_word.value < r_min) begin
                                        r_min <= i_word.value;
                                    end
                                    if (i_word.value > r_max) begin
                                        r_max <= i_word.value;
                                    end
                                end
                            end
                            ACT_QUERY: begin
                                if (w_bad) begin
                                    r_err   <= 1'b1;
                                    r_state <= ST_DONE;
                                end else begin
                                    r_err       <= 1'b0;
                                    r_lo        <= 33'(r_min);
                                    r_hi        <= 33'(r_max);
                                    r_first     <= w_first;
                                    r_last      <= w_last;
                                    r_row_first <= w_first[IDX_W-1:LANE_W];
                                    r_row_last  <= w_last[IDX_W-1:LANE_W];
                                    r_rank      <= i_word.rank;
                                    if (r_min < r_max) begin
                                        r_mid   <= f_mid(33'(r_min), 33'(r_max));
                                        r_row   <= w_first[IDX_W-1:LANE_W];
                                        r_total <= '0;
                                        r_state <= ST_SCAN;
                                    end else begin
                                        r_state <= ST_DONE;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    // Feed one row address per cycle into the head of the chain.
                    r_tok_valid <= 1'b1;
                    r_tok_row   <= r_row;
                    if (r_row == r_row_last) begin
                        r_drain <= '0;
                        r_state <= ST_DRAIN;
                    end else begin
                        r_row <= r_row + ROW_W'(1);
                    end
                end
                ST_DRAIN: begin
                    // Wait until the last row's count has reached the total.
                    r_tok_valid <= 1'b0;
                    if (r_drain == DRN_W'(DRAIN_LAST)) begin
                        r_state <= ST_STEP;
                    end else begin
                        r_drain <= r_drain + DRN_W'(1);
                    end
                end
                ST_STEP: begin
                    r_lo <= n_lo;
                    r_hi <= n_hi;
                    if (n_lo < n_hi) begin
                        r_mid   <= f_mid(n_lo, n_hi);
                        r_row   <= r_row_first;
                        r_total <= '0;
                        r_state <= ST_SCAN;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // Hold the answer until the output register is free.
                    if (!r_out_valid || i_ready) begin
                        r_out_valid     <= 1'b1;
                        r_out.kth_value <= r_err ? 32'sd0 : r_lo[31:0];
                        r_out.error     <= r_err;
                        r_state         <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    assign w_row[0]       = r_tok_row;
    assign w_row_valid[0] = r_tok_valid;
    assign w_part[0]      = '0;

    // Row of cells; bank j holds the elements whose position is j modulo NUM_CELLS.
    for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
        rkq_cell #(
            .ROW_W    (ROW_W),
            .PART_W   (PART_W),
            .CELL_IDX (j)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_we         (w_append_go && (LANE_W'(r_count) == LANE_W'(j))),
            .i_waddr      (ROW_W'(r_count >> LANE_W)),
            .i_wdata      (i_word.value),
            .i_mid        (r_mid),
            .i_first      (r_first),
            .i_last       (r_last),
            .i_row        (w_row[j]),
            .i_row_valid  (w_row_valid[j]),
            .i_part       (w_part[j]),
            .o_row        (w_row[j+1]),
            .o_row_valid  (w_row_valid[j+1]),
            .o_part       (w_part[j+1]),
            .o_part_valid (w_part_valid[j])
        );
    end

    assign w_tail_valid = w_part_valid[NUM_CELLS-1];
    assign w_tail_part  = w_part[NUM_CELLS];

    // The midpoint stays strictly above lo and at most hi while rows are counted.
    `RKQ_ASSERT_NOW(a_mid_in_bounds, i_clk, i_rst_n, (r_state == ST_SCAN),
        (r_lo < r_hi) && (r_mid > r_lo) && (r_mid <= r_hi))
    // An error result always carries a zero value.
    `RKQ_ASSERT_NOW(a_error_zero, i_clk, i_rst_n, r_out_valid && r_out.error,
        r_out.kth_value == 32'sd0)
    // An append that fits advances the count by exactly one.
    `RKQ_ASSERT_NEXT(a_append_count, i_clk, i_rst_n, w_append_go,
        r_count == $past(r_count) + CNT_W'(1))
    // Rows leaving the chain never pass the last row of the query.
    `RKQ_ASSERT_NOW(a_tail_row, i_clk, i_rst_n, w_row_valid[NUM_CELLS],
        w_row[NUM_CELLS] <= r_row_last)

endmodule

`default_nettype wire

// ===== rtl/core/rkq_cell.sv =====
// One counting cell: a bank of stored elements and a compare against the midpoint.
`timescale 1ns / 1ps
`default_nettype none

module rkq_cell import rkq_pkg::*; #(
    parameter int ROW_W    = DEF_ROW_W,
    parameter int PART_W   = DEF_PART_W,
    parameter int CELL_IDX = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_we,
    input  logic [ROW_W-1:0]        i_waddr,
    input  logic signed [31:0]      i_wdata,
    input  logic signed [32:0]      i_mid,
    input  logic [ROW_W+LANE_W-1:0] i_first,
    input  logic [ROW_W+LANE_W-1:0] i_last,
    input  logic [ROW_W-1:0]        i_row,
    input  logic                    i_row_valid,
    input  logic [PART_W-1:0]       i_part,
    output logic [ROW_W-1:0]        o_row,
    output logic                    o_row_valid,
    output logic [PART_W-1:0]       o_part,
    output logic                    o_part_valid
);

    localparam int DEPTH = 1 << ROW_W;
    localparam int IDX_W = ROW_W + LANE_W;

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;
    logic [ROW_W-1:0]   r_drow;
    logic               r_dvalid;
    logic [PART_W-1:0]  r_part;
    logic               r_part_valid;

    logic [IDX_W-1:0]   w_idx;
    logic               w_hit;

    // Position of the element now in the read register.
    assign w_idx = {r_drow, LANE_W'(CELL_IDX)};
    assign w_hit = r_dvalid && (w_idx >= i_first) && (w_idx <= i_last) &&
                   (33'(r_rdata) < i_mid);

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_row];
        r_drow  <= i_row;
        r_part  <= i_part + PART_W'(w_hit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvalid     <= 1'b0;
            r_part_valid <= 1'b0;
        end else begin
            r_dvalid     <= i_row_valid;
            r_part_valid <= r_dvalid;
        end
    end

    // Hand the row address on in the cycle before the partial count.
    assign o_row        = r_drow;
    assign o_row_valid  = r_dvalid;
    assign o_part       = r_part;
    assign o_part_valid = r_part_valid;

endmodule

`default_nettype wire
